>>> hw/rtl/rfd_pkg.sv
// Shared types, constants and field helpers for the remote frame decoder.
// No dependencies; every other RTL file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

    localparam int FRAME_LENGTH = 14;
    localparam int IDX_W        = $clog2(FRAME_LENGTH);

    // Byte positions inside a frame
    localparam int POS_ID       = 4;
    localparam int POS_WORD_A   = 5;
    localparam int POS_WORD_Y   = 7;
    localparam int POS_WORD_D   = 9;
    localparam int POS_WORD_ANG = 11;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BTN_A   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BTN_B   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BTN_C   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_STICK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT = 3'd5;

    // Frame kinds
    localparam logic [2:0] KIND_A       = 3'd0;
    localparam logic [2:0] KIND_B       = 3'd1;
    localparam logic [2:0] KIND_C       = 3'd2;
    localparam logic [2:0] KIND_STICK   = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN = 3'd4;

    // floor(w / 10) == (w * 0xCCCD) >> 19 for every 16-bit w
    localparam logic [15:0] ANGLE_RECIP = 16'hCCCD;
    localparam int          ANGLE_SHIFT = 19;
    localparam int          ANGLE_W     = 13;

    typedef logic [FRAME_LENGTH-1:0][7:0] t_frame;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  id_btn_a;
        logic [7:0]  id_btn_b;
        logic [7:0]  id_btn_c;
        logic [7:0]  id_stick;
        logic [15:0] dist_limit;
    } t_cfg;

    // Listed from the top bit down, so frame_kind lands in the lowest bits
    typedef struct packed {
        logic [ANGLE_W-1:0] stick_angle;
        logic [15:0]        stick_distance;
        logic [15:0]        stick_y;
        logic [15:0]        stick_x;
        logic [15:0]        count_c;
        logic [15:0]        count_b;
        logic [15:0]        count_a;
        logic [2:0]         frame_kind;
    } t_result;

    // Little-endian word starting at a fixed byte position
    function automatic logic [15:0] word_at(input t_frame f, input int pos);
        return {f[pos+1], f[pos]};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/remote_frame_decoder_unit.sv
// Top level of the remote frame decoder: configuration registers and stream ports.
// Depends on rfd_pkg, rfd_framer and rfd_decode.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one received byte per cycle. Bytes are dropped until the start
// byte arrives; it and the following bytes form a 14-byte frame. The result for a
// frame reaches m_axis after its last byte is taken, by way of the byte store and
// then the device select, the divide-by-ten multiplier and the result register.
// Input stalls only while a finished frame waits behind an untaken result.
// Each result carries the frame kind and all held counts and joystick values.
// Configuration writes are always ready; write them only while no frame is in flight.
module remote_frame_decoder_unit
    import rfd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [2:0] frame_kind, [18:3] count_a, [34:19] count_b, [50:35] count_c,
    // [66:51] stick_x, [82:67] stick_y, [98:83] stick_distance, [111:99] stick_angle
    output logic [111:0]              m_axis_tdata
);

    t_cfg    r_cfg;
    logic    req_vld;
    logic    take;
    t_frame  frame;
    logic    out_vld;
    t_result result;
    logic    byte_vld;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte <= 8'd85;
            r_cfg.id_btn_a   <= 8'd1;
            r_cfg.id_btn_b   <= 8'd2;
            r_cfg.id_btn_c   <= 8'd3;
            r_cfg.id_stick   <= 8'd4;
            r_cfg.dist_limit <= 16'd2400;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_BYTE: r_cfg.start_byte <= i_cfg_data[7:0];
                CFG_ID_BTN_A:   r_cfg.id_btn_a   <= i_cfg_data[7:0];
                CFG_ID_BTN_B:   r_cfg.id_btn_b   <= i_cfg_data[7:0];
                CFG_ID_BTN_C:   r_cfg.id_btn_c   <= i_cfg_data[7:0];
                CFG_ID_STICK:   r_cfg.id_stick   <= i_cfg_data[7:0];
                CFG_DIST_LIMIT: r_cfg.dist_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold input while a decoded frame and an untaken result are both pending
    assign s_axis_tready = !(req_vld && out_vld);
    assign byte_vld      = s_axis_tvalid && s_axis_tready;

    rfd_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_byte (r_cfg.start_byte),
        .i_byte_vld   (byte_vld),
        .i_byte       (s_axis_tdata),
        .i_take       (take),
        .o_req_vld    (req_vld),
        .o_frame      (frame)
    );

    rfd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req_vld   (req_vld),
        .i_frame     (frame),
        .i_out_ready (m_axis_tready),
        .o_take      (take),
        .o_out_vld   (out_vld),
        .o_result    (result)
    );

    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata  = result;

endmodule

`default_nettype wire

>>> hw/rtl/rfd_framer.sv
// Frame hunter and byte store: tracks the byte position and keeps the frame bytes.
// Depends on rfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfd_framer
    import rfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_start_byte,
    input  wire logic       i_byte_vld,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_take,
    output logic            o_req_vld,
    output t_frame          o_frame
);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_req_vld;
    logic             frame_done;
    t_frame           r_frame;

    always_comb begin
        n_idx      = r_idx;
        frame_done = 1'b0;
        if (r_idx == '0) begin
            // hunt: drop anything but the start byte
            if (i_byte == i_start_byte) begin
                n_idx = IDX_W'(1);
            end
        end else if (r_idx == IDX_W'(FRAME_LENGTH - 1)) begin
            n_idx      = '0;
            frame_done = 1'b1;
        end else begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_req_vld <= 1'b0;
        end else begin
            if (i_byte_vld) begin
                r_idx <= n_idx;
            end
            if (i_byte_vld && frame_done) begin
                r_req_vld <= 1'b1;
            end else if (i_take) begin
                r_req_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_vld && (r_idx != '0 || i_byte == i_start_byte)) begin
            r_frame[r_idx] <= i_byte;
        end
    end

    assign o_req_vld = r_req_vld;
    assign o_frame   = r_frame;

endmodule

`default_nettype wire

>>> hw/rtl/rfd_decode.sv
// Frame decoder: selects the device, updates the held values, registers the result.
// Depends on rfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfd_decode
    import rfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    input  wire logic    i_req_vld,
    input  wire t_frame  i_frame,
    input  wire logic    i_out_ready,
    output logic         o_take,
    output logic         o_out_vld,
    output t_result      o_result
);

    t_result     r_held, n_held;
    t_result     r_out;
    logic        r_out_vld;
    logic [7:0]  dev_id;
    logic [15:0] w_first;
    logic [15:0] w_dist;
    logic [15:0] w_angle;
    logic [31:0] angle_prod;

    assign dev_id     = i_frame[POS_ID];
    assign w_first    = word_at(i_frame, POS_WORD_A);
    assign w_dist     = word_at(i_frame, POS_WORD_D);
    assign w_angle    = word_at(i_frame, POS_WORD_ANG);
    assign angle_prod = 32'(w_angle) * 32'(ANGLE_RECIP);

    // First match wins: button A, B, C, then joystick
    always_comb begin
        n_held = r_held;
        if (dev_id == i_cfg.id_btn_a) begin
            n_held.frame_kind = KIND_A;
            n_held.count_a    = w_first;
        end else if (dev_id == i_cfg.id_btn_b) begin
            n_held.frame_kind = KIND_B;
            n_held.count_b    = w_first;
        end else if (dev_id == i_cfg.id_btn_c) begin
            n_held.frame_kind = KIND_C;
            n_held.count_c    = w_first;
        end else if (dev_id == i_cfg.id_stick) begin
            n_held.frame_kind     = KIND_STICK;
            n_held.stick_x        = w_first;
            n_held.stick_y        = word_at(i_frame, POS_WORD_Y);
            n_held.stick_distance = (w_dist > i_cfg.dist_limit) ? i_cfg.dist_limit : w_dist;
            n_held.stick_angle    = angle_prod[ANGLE_SHIFT +: ANGLE_W];
        end else begin
            n_held.frame_kind = KIND_UNKNOWN;
        end
    end

    assign o_take = i_req_vld && (!r_out_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_take) begin
                r_held    <= n_held;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_held;
        end
    end

    assign o_out_vld = r_out_vld;
    assign o_result  = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/rfd_checker.sv
// Port-level checks for remote_frame_decoder_unit, attached by bind.
// Depends on rfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfd_checker
    import rfd_pkg::*;
(
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [111:0] m_axis_tdata
);

    // no result is presented right after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a fresh result follows a closing byte taken earlier, by way of the framer and result registers
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result without a closing byte");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= KIND_UNKNOWN)
        else $error("frame kind out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[111:99] <= 13'd6553)
        else $error("angle out of range");

endmodule

bind remote_frame_decoder_unit rfd_checker u_rfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> sim/frame_result_checker.sv
// Checker for the remote frame decoder: watches the config, byte and result streams,
// predicts every frame result and compares it field by field. Depends on rfd_pkg.
`timescale 1ns / 1ps

module frame_result_checker
    import rfd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 i_byte_valid,
    input  wire logic                 i_byte_ready,
    input  wire logic [7:0]           i_byte_data,
    input  wire logic                 i_res_valid,
    input  wire logic                 i_res_ready,
    input  wire logic [111:0]         i_res_data,
    output int                        o_fail_count,
    output int                        o_pending,
    output logic [3:0]                o_frame_pos
);

    // Shadow copy of the configuration registers
    logic [7:0]  start_val;
    logic [7:0]  dev_a, dev_b, dev_c, dev_stick;
    logic [15:0] dist_ceiling;

    // Shadow copy of the decoder state
    logic [3:0]  frame_pos;
    logic [7:0]  frame_buf [16];
    logic [15:0] cnt_a, cnt_b, cnt_c, pos_x, pos_y, dist_val;
    logic [12:0] angle;

    t_result expected_results[$];

    assign o_frame_pos = frame_pos;

    function automatic logic [15:0] le_word(input int pos);
        return {frame_buf[(pos + 1) & 15], frame_buf[pos & 15]};
    endfunction

    // Advance the shadow framer by one received byte; queue a result at frame end
    task automatic decode_byte(input logic [7:0] b);
        t_result     r;
        logic [7:0]  dev;
        logic [15:0] d;
        logic [15:0] ang_word;
        if (frame_pos == 0) begin
            if (b == start_val) begin
                frame_buf[0] = b;
                frame_pos = 4'd1;
            end
            return;
        end
        frame_buf[frame_pos] = b;
        if (int'(frame_pos) + 1 < FRAME_LENGTH) begin
            frame_pos = frame_pos + 4'd1;
            return;
        end
        frame_pos = 4'd0;
        dev = frame_buf[POS_ID];
        if (dev == dev_a) begin
            cnt_a = le_word(POS_WORD_A);
            r.frame_kind = KIND_A;
        end else if (dev == dev_b) begin
            cnt_b = le_word(POS_WORD_A);
            r.frame_kind = KIND_B;
        end else if (dev == dev_c) begin
            cnt_c = le_word(POS_WORD_A);
            r.frame_kind = KIND_C;
        end else if (dev == dev_stick) begin
            pos_x = le_word(POS_WORD_A);
            pos_y = le_word(POS_WORD_Y);
            d = le_word(POS_WORD_D);
            dist_val = (d > dist_ceiling) ? dist_ceiling : d;
            ang_word = le_word(POS_WORD_ANG) / 16'd10;
            angle = ang_word[12:0];
            r.frame_kind = KIND_STICK;
        end else begin
            r.frame_kind = KIND_UNKNOWN;
        end
        r.count_a        = cnt_a;
        r.count_b        = cnt_b;
        r.count_c        = cnt_c;
        r.stick_x        = pos_x;
        r.stick_y        = pos_y;
        r.stick_distance = dist_val;
        r.stick_angle    = angle;
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            $error("result transaction with no frame pending: kind %0d", got.frame_kind);
            o_fail_count++;
            return;
        end
        want = expected_results.pop_front();
        check_field("frame_kind", want.frame_kind, got.frame_kind);
        check_field("count_a", want.count_a, got.count_a);
        check_field("count_b", want.count_b, got.count_b);
        check_field("count_c", want.count_c, got.count_c);
        check_field("stick_x", want.stick_x, got.stick_x);
        check_field("stick_y", want.stick_y, got.stick_y);
        check_field("stick_distance", want.stick_distance, got.stick_distance);
        check_field("stick_angle", want.stick_angle, got.stick_angle);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_val    = 8'd85;
            dev_a        = 8'd1;
            dev_b        = 8'd2;
            dev_c        = 8'd3;
            dev_stick    = 8'd4;
            dist_ceiling = 16'd2400;
            frame_pos    = 4'd0;
            cnt_a        = '0;
            cnt_b        = '0;
            cnt_c        = '0;
            pos_x        = '0;
            pos_y        = '0;
            dist_val     = '0;
            angle        = '0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready)
                check_result(t_result'(i_res_data));
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_BYTE: start_val    = i_cfg_data[7:0];
                    CFG_ID_BTN_A:   dev_a        = i_cfg_data[7:0];
                    CFG_ID_BTN_B:   dev_b        = i_cfg_data[7:0];
                    CFG_ID_BTN_C:   dev_c        = i_cfg_data[7:0];
                    CFG_ID_STICK:   dev_stick    = i_cfg_data[7:0];
                    CFG_DIST_LIMIT: dist_ceiling = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_byte_valid && i_byte_ready)
                decode_byte(i_byte_data);
        end
        o_pending = expected_results.size();
    end

endmodule

>>> sim/tb.sv
// Testbench top for remote_frame_decoder_unit: clock, reset, byte and config stimulus,
// result back-pressure and the verdict. Depends on rfd_pkg and frame_result_checker.
`timescale 1ns / 1ps

module tb;
    import rfd_pkg::*;

    localparam int LONG_HOLD      = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [15:0]          i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic [7:0]           s_axis_tdata  = '0;
    logic                 m_axis_tready = 1'b0;
    logic                 o_cfg_ready;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [111:0]         m_axis_tdata;

    int         fail_count;
    int         pending;
    logic [3:0] frame_pos;

    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int stall_left   = 0;
    bit hold_req     = 1'b0;
    int idle_cycles;

    // Stimulus-side view of the current configuration
    logic [7:0]  cur_start;
    logic [7:0]  cur_ids [4];
    logic [15:0] cur_limit;

    remote_frame_decoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    frame_result_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_byte_valid (s_axis_tvalid),
        .i_byte_ready (s_axis_tready),
        .i_byte_data  (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_frame_pos  (frame_pos)
    );

    always #5 i_clk = ~i_clk;

    // Result back-pressure: random stall bursts, or one long hold on request
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            stall_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_stall_pct) begin
            stall_left = $urandom_range(0, 13);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic put_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Hold valid across back-to-back writes; the caller drops it after the last one
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] start, input logic [7:0] id_a,
                              input logic [7:0] id_b, input logic [7:0] id_c,
                              input logic [7:0] id_stick, input logic [15:0] limit);
        // byte registers get junk in the upper data bits
        cfg_write(CFG_START_BYTE, {8'($urandom_range(0, 255)), start});
        cfg_write(CFG_ID_BTN_A, {8'($urandom_range(0, 255)), id_a});
        cfg_write(CFG_ID_BTN_B, {8'($urandom_range(0, 255)), id_b});
        cfg_write(CFG_ID_BTN_C, {8'($urandom_range(0, 255)), id_c});
        cfg_write(CFG_ID_STICK, {8'($urandom_range(0, 255)), id_stick});
        cfg_write(CFG_DIST_LIMIT, limit);
        i_cfg_valid <= 1'b0;
        cur_start  = start;
        cur_ids[0] = id_a;
        cur_ids[1] = id_b;
        cur_ids[2] = id_c;
        cur_ids[3] = id_stick;
        cur_limit  = limit;
    endtask

    task automatic random_config();
        logic [7:0]  ids [4];
        logic [15:0] limit;
        ids[0] = 8'($urandom_range(0, 255));
        for (int i = 1; i < 4; i++)
            ids[i] = ($urandom_range(0, 3) == 0) ? ids[$urandom_range(0, i - 1)]
                                                 : 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       limit = 16'h0000;
            1:       limit = 16'hFFFF;
            default: limit = 16'($urandom_range(0, 65535));
        endcase
        set_config(8'($urandom_range(0, 255)), ids[0], ids[1], ids[2], ids[3], limit);
    endtask

    // Stop sending and wait until every frame result has been taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] n;
        n = 8'($urandom_range(0, 255));
        if (n == cur_start)
            n = ~n;
        return n;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return cur_limit;
            3:       return cur_limit + 16'd1;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Finish any partial frame so the decoder is hunting before a config change
    task automatic close_phase();
        int fill;
        drain();
        if (frame_pos != 0) begin
            fill = FRAME_LENGTH - int'(frame_pos);
            repeat (fill) put_byte(8'($urandom_range(0, 255)));
            drain();
        end
    endtask

    task automatic send_frame(input logic [7:0] dev, input logic [15:0] w_a,
                              input logic [15:0] w_y, input logic [15:0] w_d,
                              input logic [15:0] w_ang, input bit fill_start);
        logic [7:0] frame [FRAME_LENGTH];
        for (int i = 0; i < FRAME_LENGTH; i++)
            frame[i] = fill_start ? cur_start : 8'($urandom_range(0, 255));
        frame[0]      = cur_start;
        frame[POS_ID] = dev;
        {frame[POS_WORD_A + 1], frame[POS_WORD_A]}     = w_a;
        {frame[POS_WORD_Y + 1], frame[POS_WORD_Y]}     = w_y;
        {frame[POS_WORD_D + 1], frame[POS_WORD_D]}     = w_d;
        {frame[POS_WORD_ANG + 1], frame[POS_WORD_ANG]} = w_ang;
        foreach (frame[i]) put_byte(frame[i]);
    endtask

    task automatic random_frame();
        logic [7:0] dev;
        int         pick;
        if ($urandom_range(0, 9) < 3)
            repeat ($urandom_range(1, 3)) put_byte(noise_byte());
        pick = $urandom_range(0, 4);
        dev = (pick == 4) ? 8'($urandom_range(0, 255)) : cur_ids[pick];
        send_frame(dev, rand_word(), rand_word(), rand_word(), rand_word(),
                   $urandom_range(0, 7) == 0);
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cur_start  = 8'd85;
        cur_ids[0] = 8'd1;
        cur_ids[1] = 8'd2;
        cur_ids[2] = 8'd3;
        cur_ids[3] = 8'd4;
        cur_limit  = 16'd2400;
        tx_gap_pct   = 20;
        rx_stall_pct = 20;

        // Power-up settings: stray bytes, then one frame of each kind and a second joystick frame
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h54);
        send_frame(cur_ids[0], 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_frame(cur_ids[1], 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_frame(cur_ids[2], 16'h8001, 16'h1234, 16'h4321, 16'h00FF, 1'b0);
        // start byte repeated inside the frame, distance and angle at their maximum
        send_frame(cur_ids[3], 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_frame(8'h00, 16'h5A5A, 16'hA5A5, 16'h0001, 16'h0002, 1'b0);
        // distance exactly at the limit, angle below ten
        send_frame(cur_ids[3], 16'h8000, 16'h7FFF, 16'd2400, 16'd9, 1'b0);
        close_phase();

        // Shared ids and a zero distance ceiling
        set_config(8'h00, 8'd9, 8'd9, 8'd200, 8'd200, 16'h0000);
        repeat (5) random_frame();
        close_phase();

        set_config(8'hFF, 8'hFF, 8'h00, 8'h80, 8'h01, 16'hFFFF);
        repeat (5) random_frame();
        close_phase();

        for (int p = 0; p < 4; p++) begin
            random_config();
            tx_gap_pct   = pick_pct();
            rx_stall_pct = pick_pct();
            // one phase keeps offering bytes against a long result stall
            if (p == 1) begin
                tx_gap_pct = 0;
                hold_req   = 1'b1;
            end
            repeat (4) random_frame();
            close_phase();
        end

        random_config();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        repeat (5) random_frame();
        close_phase();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
